FILE: design/grwt_pkg.sv
`default_nettype none

package grwt_pkg;

  // Input item opcodes
  typedef enum logic [1:0] {
    MODE_LOAD_ADJ  = 2'd0,
    MODE_LOAD_NODE = 2'd1,
    MODE_START     = 2'd2,
    MODE_STEP      = 2'd3
  } mode_t;

  // Sequencer states, one-hot
  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_WRAP     = 18'h00002,
    S_DISPATCH = 18'h00004,
    S_ADJ_WR   = 18'h00008,
    S_NODE_RD  = 18'h00010,
    S_NODE_WR  = 18'h00020,
    S_START    = 18'h00040,
    S_CLR      = 18'h00080,
    S_VISIT_RD = 18'h00100,
    S_VISIT_WR = 18'h00200,
    S_STEP_RD  = 18'h00400,
    S_STEP_CHK = 18'h00800,
    S_DIV      = 18'h01000,
    S_DIV_CHK  = 18'h02000,
    S_ADJ_RD   = 18'h04000,
    S_ADJ_USE  = 18'h08000,
    S_MOVE     = 18'h10000,
    S_DONE     = 18'h20000
  } state_t;

  // Node memory word: visited flag, degree, distance
  localparam int NODE_W   = 16;
  localparam int VIS_BIT  = 15;
  localparam int DEG_HI   = 14;
  localparam int DEG_LO   = 10;
  localparam int DIST_HI  = 9;
  localparam int DIST_LO  = 0;

  // Rejection scale floor(0xFFFFFFFF / d) for a 5-bit degree
  function automatic logic [31:0] scale_of(input logic [4:0] d);
    logic [31:0] s;
    case (d)
      5'd1:    s = 32'hFFFFFFFF;
      5'd2:    s = 32'h7FFFFFFF;
      5'd3:    s = 32'h55555555;
      5'd4:    s = 32'h3FFFFFFF;
      5'd5:    s = 32'h33333333;
      5'd6:    s = 32'h2AAAAAAA;
      5'd7:    s = 32'h24924924;
      5'd8:    s = 32'h1FFFFFFF;
      5'd9:    s = 32'h1C71C71C;
      5'd10:   s = 32'h19999999;
      5'd11:   s = 32'h1745D174;
      5'd12:   s = 32'h15555555;
      5'd13:   s = 32'h13B13B13;
      5'd14:   s = 32'h12492492;
      5'd15:   s = 32'h11111111;
      5'd16:   s = 32'h0FFFFFFF;
      5'd17:   s = 32'h0F0F0F0F;
      5'd18:   s = 32'h0E38E38E;
      5'd19:   s = 32'h0D79435E;
      5'd20:   s = 32'h0CCCCCCC;
      5'd21:   s = 32'h0C30C30C;
      5'd22:   s = 32'h0BA2E8BA;
      5'd23:   s = 32'h0B21642C;
      5'd24:   s = 32'h0AAAAAAA;
      5'd25:   s = 32'h0A3D70A3;
      5'd26:   s = 32'h09D89D89;
      5'd27:   s = 32'h097B425E;
      5'd28:   s = 32'h09249249;
      5'd29:   s = 32'h08D3DCB0;
      5'd30:   s = 32'h08888888;
      5'd31:   s = 32'h08421084;
      default: s = 32'hFFFFFFFF;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: design/graph_random_walk_territory_core.sv
`default_nettype none

// Channel   Direction  Transfer when            Payload
// command   in         start && !busy          mode node slot neighbor degree
//                                              target_distance random_word
// result    out        done (one cycle)        position steps_taken
//                                              distinct_visited max_distance alive rejected
// config    in         psel&penable&pwrite     target_node at byte address 0
//
// One item at a time. A step waits on the restoring divider and on two
// dependent memory reads (node, then adjacency); a node id fold runs its
// restoring steps only for an id of MAX_NODES or more, which needs MAX_NODES
// below 1024.
// A start, and reset itself, run a clearing pass over the node memory,
// during which busy stays high.
// The receiver cannot stall: each result shows for exactly one cycle.
module graph_random_walk_territory_core #(
  parameter int MAX_NODES  = 1024,
  parameter int MAX_DEGREE = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  mode,
  input  wire logic [9:0]  node,
  input  wire logic [3:0]  slot,
  input  wire logic [9:0]  neighbor,
  input  wire logic [4:0]  degree,
  input  wire logic [9:0]  target_distance,
  input  wire logic [31:0] random_word,
  // result
  output logic             done,
  output logic [9:0]       position,
  output logic [31:0]      steps_taken,
  output logic [10:0]      distinct_visited,
  output logic [9:0]       max_distance,
  output logic             alive,
  output logic             rejected,
  // config
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int ADJ_DEPTH = MAX_NODES * MAX_DEGREE;
  localparam int ADJ_AW = (ADJ_DEPTH > 1) ? $clog2(ADJ_DEPTH) : 1;
  localparam logic [1:0] ADDR_TARGET = 2'd0;

  grwt_pkg::state_t state, wrap_ret;

  // config
  logic [9:0] target_node;
  // latched command
  logic [1:0]  req_mode;
  logic [9:0]  req_node;
  logic [3:0]  req_slot;
  logic [9:0]  req_nb;
  logic [4:0]  req_deg;
  logic [9:0]  req_dist;
  logic [31:0] req_word;
  // walk state
  logic [9:0]  tgt_w;
  logic [9:0]  walk_pos;
  logic [31:0] step_count;
  logic [10:0] distinct_count;
  logic [9:0]  farthest;
  logic        rej;
  // node id fold unit
  logic [9:0]  wrap_val;
  logic [3:0]  wrap_k;
  logic [25:0] wrap_sub;
  // divider
  logic [31:0] div_rem;
  logic [31:0] div_scale;
  logic [5:0]  div_q;
  logic [2:0]  div_i;
  logic [4:0]  cur_deg;
  logic [37:0] div_sub;
  // clearing pass
  logic [NODE_AW:0]   clr_idx;
  logic               clr_pend;
  logic [NODE_AW-1:0] clr_addr;
  logic               clr_start;
  logic               clr_rd;
  // address
  logic [ADJ_AW-1:0]  adj_addr;
  // memory ports
  logic                  adj_we, adj_re;
  logic [ADJ_AW-1:0]     adj_waddr, adj_raddr;
  logic [9:0]            adj_rdata;
  logic                  nd_we, nd_re;
  logic [NODE_AW-1:0]    nd_waddr, nd_raddr;
  logic [grwt_pkg::NODE_W-1:0] nd_wdata, nd_rdata;

  logic cfg_wr;
  logic node_ok, slot_ok;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = {22'd0, target_node};

  assign busy = (state != grwt_pkg::S_IDLE);
  assign done = (state == grwt_pkg::S_DONE);
  assign position = walk_pos;
  assign steps_taken = step_count;
  assign distinct_visited = distinct_count;
  assign max_distance = farthest;
  assign alive = (walk_pos != tgt_w);
  assign rejected = rej;

  assign wrap_sub = 26'(MAX_NODES) << wrap_k;
  assign div_sub = 38'(div_scale) << div_i;
  assign clr_rd = (32'(clr_idx) < 32'(MAX_NODES));
  assign node_ok = (32'(req_node) < 32'(MAX_NODES));
  assign slot_ok = (32'(req_slot) < 32'(MAX_DEGREE));

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      target_node <= '0;
    end else if (cfg_wr && paddr == ADDR_TARGET) begin
      target_node <= pwdata[9:0];
    end
  end

  // Memory port steering
  always_comb begin
    adj_we    = 1'b0;
    adj_waddr = adj_addr;
    adj_re    = 1'b0;
    adj_raddr = adj_addr;
    nd_we     = 1'b0;
    nd_waddr  = NODE_AW'(req_node);
    nd_wdata  = {nd_rdata[grwt_pkg::VIS_BIT], req_deg, req_dist};
    nd_re     = 1'b0;
    nd_raddr  = NODE_AW'(walk_pos);
    case (state)
      grwt_pkg::S_ADJ_WR: adj_we = 1'b1;
      grwt_pkg::S_ADJ_RD: adj_re = 1'b1;
      grwt_pkg::S_NODE_RD: begin
        nd_re    = 1'b1;
        nd_raddr = NODE_AW'(req_node);
      end
      grwt_pkg::S_NODE_WR: nd_we = 1'b1;
      grwt_pkg::S_CLR: begin
        nd_re    = clr_rd;
        nd_raddr = clr_idx[NODE_AW-1:0];
        nd_we    = clr_pend;
        nd_waddr = clr_addr;
        nd_wdata = {1'b0, nd_rdata[grwt_pkg::DEG_HI:0]};
      end
      grwt_pkg::S_VISIT_RD, grwt_pkg::S_STEP_RD: nd_re = 1'b1;
      grwt_pkg::S_VISIT_WR: begin
        nd_we    = !nd_rdata[grwt_pkg::VIS_BIT];
        nd_waddr = NODE_AW'(walk_pos);
        nd_wdata = {1'b1, nd_rdata[grwt_pkg::DEG_HI:0]};
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= grwt_pkg::S_CLR;
      wrap_ret       <= grwt_pkg::S_IDLE;
      clr_idx        <= '0;
      clr_pend       <= 1'b0;
      clr_start      <= 1'b0;
      walk_pos       <= '0;
      step_count     <= '0;
      distinct_count <= '0;
      farthest       <= '0;
      tgt_w          <= '0;
      rej            <= 1'b0;
    end else begin
      case (state)
        grwt_pkg::S_IDLE: begin
          if (start) begin
            req_mode <= mode;
            req_node <= node;
            req_slot <= slot;
            req_nb   <= neighbor;
            req_deg  <= degree;
            req_dist <= target_distance;
            req_word <= random_word;
            wrap_val <= target_node;
            wrap_k   <= 4'd9;
            wrap_ret <= grwt_pkg::S_DISPATCH;
            state    <= grwt_pkg::S_WRAP;
          end
        end

        // Fold a node id below MAX_NODES, one restoring step a cycle
        grwt_pkg::S_WRAP: begin
          if (32'(wrap_val) < 32'(MAX_NODES)) begin
            state <= wrap_ret;
          end else begin
            if (26'(wrap_val) >= wrap_sub) begin
              wrap_val <= 10'(26'(wrap_val) - wrap_sub);
            end
            wrap_k <= wrap_k - 4'd1;
          end
        end

        grwt_pkg::S_DISPATCH: begin
          tgt_w <= wrap_val;
          rej   <= 1'b0;
          case (grwt_pkg::mode_t'(req_mode))
            grwt_pkg::MODE_LOAD_ADJ: begin
              adj_addr <= ADJ_AW'(32'(req_node) * 32'(MAX_DEGREE) + 32'(req_slot));
              state    <= (node_ok && slot_ok) ? grwt_pkg::S_ADJ_WR : grwt_pkg::S_DONE;
            end
            grwt_pkg::MODE_LOAD_NODE: begin
              state <= node_ok ? grwt_pkg::S_NODE_RD : grwt_pkg::S_DONE;
            end
            grwt_pkg::MODE_START: begin
              wrap_val <= req_node;
              wrap_k   <= 4'd9;
              wrap_ret <= grwt_pkg::S_START;
              state    <= grwt_pkg::S_WRAP;
            end
            grwt_pkg::MODE_STEP: begin
              state <= (walk_pos == wrap_val) ? grwt_pkg::S_DONE : grwt_pkg::S_STEP_RD;
            end
            default: state <= grwt_pkg::S_DONE;
          endcase
        end

        grwt_pkg::S_ADJ_WR:  state <= grwt_pkg::S_DONE;
        grwt_pkg::S_NODE_RD: state <= grwt_pkg::S_NODE_WR;
        grwt_pkg::S_NODE_WR: state <= grwt_pkg::S_DONE;

        grwt_pkg::S_START: begin
          walk_pos       <= wrap_val;
          step_count     <= '0;
          distinct_count <= '0;
          farthest       <= '0;
          clr_idx        <= '0;
          clr_pend       <= 1'b0;
          clr_start      <= 1'b1;
          state          <= grwt_pkg::S_CLR;
        end

        // Read entry i while writing back entry i-1 with visited cleared
        grwt_pkg::S_CLR: begin
          clr_pend <= clr_rd;
          clr_addr <= clr_idx[NODE_AW-1:0];
          if (clr_rd) begin
            clr_idx <= clr_idx + (NODE_AW+1)'(1);
          end else if (!clr_pend) begin
            state <= clr_start ? grwt_pkg::S_VISIT_RD : grwt_pkg::S_IDLE;
          end
        end

        grwt_pkg::S_VISIT_RD: state <= grwt_pkg::S_VISIT_WR;

        grwt_pkg::S_VISIT_WR: begin
          if (!nd_rdata[grwt_pkg::VIS_BIT] && distinct_count != 11'h7FF) begin
            distinct_count <= distinct_count + 11'd1;
          end
          if (nd_rdata[grwt_pkg::DIST_HI:grwt_pkg::DIST_LO] > farthest) begin
            farthest <= nd_rdata[grwt_pkg::DIST_HI:grwt_pkg::DIST_LO];
          end
          state <= grwt_pkg::S_DONE;
        end

        grwt_pkg::S_STEP_RD: state <= grwt_pkg::S_STEP_CHK;

        grwt_pkg::S_STEP_CHK: begin
          cur_deg   <= nd_rdata[grwt_pkg::DEG_HI:grwt_pkg::DEG_LO];
          div_scale <= grwt_pkg::scale_of(nd_rdata[grwt_pkg::DEG_HI:grwt_pkg::DEG_LO]);
          div_rem   <= req_word;
          div_q     <= '0;
          div_i     <= 3'd5;
          if (nd_rdata[grwt_pkg::DEG_HI:grwt_pkg::DEG_LO] == 5'd0 ||
              32'(nd_rdata[grwt_pkg::DEG_HI:grwt_pkg::DEG_LO]) > 32'(MAX_DEGREE)) begin
            rej   <= 1'b1;
            state <= grwt_pkg::S_DONE;
          end else begin
            state <= grwt_pkg::S_DIV;
          end
        end

        // Restoring divide, one quotient bit a cycle
        grwt_pkg::S_DIV: begin
          if (38'(div_rem) >= div_sub) begin
            div_rem      <= 32'(38'(div_rem) - div_sub);
            div_q[div_i] <= 1'b1;
          end
          div_i <= div_i - 3'd1;
          if (div_i == 3'd0) begin
            state <= grwt_pkg::S_DIV_CHK;
          end
        end

        grwt_pkg::S_DIV_CHK: begin
          adj_addr <= ADJ_AW'(32'(walk_pos) * 32'(MAX_DEGREE) + 32'(div_q));
          if (div_q >= 6'(cur_deg)) begin
            rej   <= 1'b1;
            state <= grwt_pkg::S_DONE;
          end else begin
            state <= grwt_pkg::S_ADJ_RD;
          end
        end

        grwt_pkg::S_ADJ_RD: state <= grwt_pkg::S_ADJ_USE;

        grwt_pkg::S_ADJ_USE: begin
          wrap_val <= adj_rdata;
          wrap_k   <= 4'd9;
          wrap_ret <= grwt_pkg::S_MOVE;
          state    <= grwt_pkg::S_WRAP;
        end

        grwt_pkg::S_MOVE: begin
          walk_pos <= wrap_val;
          if (step_count != 32'hFFFFFFFF) begin
            step_count <= step_count + 32'd1;
          end
          state <= grwt_pkg::S_VISIT_RD;
        end

        grwt_pkg::S_DONE: state <= grwt_pkg::S_IDLE;

        default: state <= grwt_pkg::S_IDLE;
      endcase
    end
  end

  // Neighbor lists
  grwt_ram #(
    .WIDTH(10),
    .DEPTH(ADJ_DEPTH)
  ) u_adj_ram (
    .clk  (clk),
    .we   (adj_we),
    .waddr(adj_waddr),
    .wdata(req_nb),
    .re   (adj_re),
    .raddr(adj_raddr),
    .rdata(adj_rdata)
  );

  // Per-node visited flag, degree and distance
  grwt_ram #(
    .WIDTH(grwt_pkg::NODE_W),
    .DEPTH(MAX_NODES)
  ) u_node_ram (
    .clk  (clk),
    .we   (nd_we),
    .waddr(nd_waddr),
    .wdata(nd_wdata),
    .re   (nd_re),
    .raddr(nd_raddr),
    .rdata(nd_rdata)
  );

`ifndef ASSERT_OFF
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");
  a_reject_step: assert property (@(posedge clk) disable iff (rst)
    (done && rejected) |-> (req_mode == grwt_pkg::MODE_STEP))
    else $error("reject flagged on a non-step command");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(walk_pos) < 32'(MAX_NODES)))
    else $error("walker position out of range");
`endif

endmodule

`default_nettype wire

FILE: design/grwt_ram.sv
`default_nettype none

// Simple dual-port RAM, registered read
module grwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none

module testbench;

  // Result fields of one transfer
  typedef struct packed {
    logic [9:0]  position;
    logic [31:0] steps;
    logic [10:0] visited;
    logic [9:0]  far;
    logic        alive;
    logic        rejected;
  } walk_result_t;

  // One command, with an optional hand-written result
  typedef struct {
    grwt_pkg::mode_t mode;
    logic [9:0]   node;
    logic [3:0]   slot;
    logic [9:0]   nbr;
    logic [4:0]   deg;
    logic [9:0]   tdist;
    logic [31:0]  word;
    bit           typed;
    walk_result_t res;
  } walk_cmd_t;

  localparam int NODES      = 1024;
  localparam int DEGREE_MAX = 16;
  localparam int RAND_ITEMS = 500;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [1:0] REG_TARGET = 2'd0;

  logic clk, rst;
  logic start, busy, done;
  grwt_pkg::mode_t mode;
  logic [9:0] node, neighbor, target_distance;
  logic [3:0] slot;
  logic [4:0] degree;
  logic [31:0] random_word;
  logic [9:0] position, max_distance;
  logic [31:0] steps_taken;
  logic [10:0] distinct_visited;
  logic alive, rejected;
  logic psel, penable, pwrite, pready;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;

  graph_random_walk_territory_core DUT (
    .clk, .rst, .start, .busy, .mode, .node, .slot, .neighbor, .degree,
    .target_distance, .random_word, .done, .position, .steps_taken,
    .distinct_visited, .max_distance, .alive, .rejected,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Walker copy of the block state
  logic [9:0] walk_adj [NODES*DEGREE_MAX];
  logic [4:0] walk_deg [NODES];
  logic [9:0] walk_dist [NODES];
  bit         walk_seen [NODES];
  logic [9:0] walk_pos, walk_target, walk_far;
  logic [31:0] walk_steps;
  logic [10:0] walk_count;

  // Which store entries have been written, so no unwritten entry is read
  bit adj_known [NODES*DEGREE_MAX];
  bit node_known [NODES];
  int known_list [$];

  walk_result_t expected_results [$];
  int mismatches;
  int cycles;
  walk_cmd_t tbl [$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic void mark_seen(logic [9:0] n);
    if (!walk_seen[n]) begin
      walk_seen[n] = 1;
      if (walk_count != 11'h7FF) walk_count++;
    end
    if (walk_dist[n] > walk_far) walk_far = walk_dist[n];
  endfunction

  function automatic walk_result_t walk_predict(walk_cmd_t c);
    walk_result_t r;
    logic [31:0] scale, k;
    bit rj;
    rj = 0;
    case (c.mode)
      grwt_pkg::MODE_LOAD_ADJ: walk_adj[c.node*DEGREE_MAX + c.slot] = c.nbr;
      grwt_pkg::MODE_LOAD_NODE: begin
        walk_deg[c.node] = c.deg;
        walk_dist[c.node] = c.tdist;
      end
      grwt_pkg::MODE_START: begin
        foreach (walk_seen[i]) walk_seen[i] = 0;
        walk_pos = c.node;
        walk_steps = 0;
        walk_count = 0;
        walk_far = 0;
        mark_seen(walk_pos);
      end
      default: begin
        if (walk_pos != walk_target) begin
          if (walk_deg[walk_pos] == 0 || walk_deg[walk_pos] > DEGREE_MAX) begin
            rj = 1;
          end else begin
            scale = 32'hFFFFFFFF / walk_deg[walk_pos];
            k = c.word / scale;
            if (k >= walk_deg[walk_pos]) begin
              rj = 1;
            end else begin
              walk_pos = walk_adj[walk_pos*DEGREE_MAX + k];
              if (walk_steps != 32'hFFFFFFFF) walk_steps++;
              mark_seen(walk_pos);
            end
          end
        end
      end
    endcase
    r.position = walk_pos;
    r.steps = walk_steps;
    r.visited = walk_count;
    r.far = walk_far;
    r.alive = (walk_pos != walk_target);
    r.rejected = rj;
    return r;
  endfunction

  // A step word that never makes the block read an unwritten entry;
  // all-ones is rejected for every degree
  function automatic logic [31:0] safe_word(logic [31:0] w);
    logic [4:0] d;
    logic [31:0] k;
    int a;
    if (walk_pos == walk_target) return w;
    d = walk_deg[walk_pos];
    if (d == 0 || d > DEGREE_MAX) return w;
    k = w / (32'hFFFFFFFF / d);
    if (k >= d) return w;
    a = walk_pos*DEGREE_MAX + k;
    if (!adj_known[a] || !node_known[walk_adj[a]]) return 32'hFFFFFFFF;
    return w;
  endfunction

  function automatic walk_cmd_t cmd(grwt_pkg::mode_t m, int n, int s, int nb, int d,
                                    int ds, logic [31:0] w, bit t = 0, int p = 0,
                                    int st = 0, int dv = 0, int md = 0, bit al = 0,
                                    bit rj = 0);
    walk_cmd_t c;
    c.mode = m; c.node = 10'(n); c.slot = 4'(s); c.nbr = 10'(nb); c.deg = 5'(d);
    c.tdist = 10'(ds); c.word = w; c.typed = t;
    c.res = '{position: 10'(p), steps: 32'(st), visited: 11'(dv), far: 10'(md),
              alive: al, rejected: rj};
    return c;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(walk_cmd_t c);
    tbl = {tbl, c};
  endfunction

  function automatic int pick_known();
    return known_list[$urandom_range(known_list.size() - 1)];
  endfunction

  // Send one command; the transfer happens at the edge with start high and busy low
  task automatic send(walk_cmd_t c);
    walk_result_t r;
    int gap;
    gap = $urandom_range(3) == 0 ? 0 : $urandom_range(12);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    if (c.mode == grwt_pkg::MODE_STEP) c.word = safe_word(c.word);
    start <= 1;
    mode <= c.mode; node <= c.node; slot <= c.slot; neighbor <= c.nbr;
    degree <= c.deg; target_distance <= c.tdist; random_word <= c.word;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (c.mode == grwt_pkg::MODE_LOAD_ADJ) adj_known[c.node*DEGREE_MAX + c.slot] = 1;
    if (c.mode == grwt_pkg::MODE_LOAD_NODE && !node_known[c.node]) begin
      node_known[c.node] = 1;
      known_list = {known_list, int'(c.node)};
    end
    r = walk_predict(c);
    if (c.typed) r = c.res;
    expected_results = {expected_results, r};
  endtask

  // Register write while idle: drain results first
  task automatic write_target(logic [9:0] v);
    start <= 0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    while (busy) @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= REG_TARGET; pwdata <= {22'd0, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    walk_target = v;
  endtask

  // Random command of a well-formed walk, with some noise
  function automatic walk_cmd_t random_cmd();
    walk_cmd_t c;
    int r;
    c = cmd(grwt_pkg::MODE_STEP, $urandom_range(1023), $urandom_range(15),
            $urandom_range(1023), $urandom_range(31), $urandom_range(1023), $urandom());
    r = $urandom_range(99);
    if (walk_pos != walk_target && !node_known[walk_pos]) begin
      c.mode = grwt_pkg::MODE_LOAD_NODE;
      c.node = walk_pos;
      c.deg = 5'($urandom_range(1, 4));
    end else if (r < 12) begin
      c.mode = grwt_pkg::MODE_LOAD_NODE;
      if ($urandom_range(9) < 3) c.node = 10'(pick_known());
      r = $urandom_range(9);
      if (r < 8) c.deg = 5'($urandom_range(1, 4));
      else if (r == 8) c.deg = 5'($urandom_range(16));
      else c.deg = 5'($urandom_range(17, 31));
    end else if (r < 35) begin
      c.mode = grwt_pkg::MODE_LOAD_ADJ;
      if ($urandom_range(99) < 85) c.node = 10'(pick_known());
      if ($urandom_range(9) < 8) c.slot = 4'($urandom_range(3));
      if ($urandom_range(99) < 85) c.nbr = 10'(pick_known());
    end else if (r < 42) begin
      c.mode = grwt_pkg::MODE_START;
      c.node = 10'(pick_known());
    end else begin
      r = $urandom_range(19);
      if (r == 0) c.word = 32'hFFFFFFFF;
      else if (r == 1) c.word = 0;
    end
    return c;
  endfunction

  always @(posedge clk) begin
    walk_result_t e;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        if (mismatches < 10) $display("unexpected result: position %0d", position);
        mismatches++;
      end else begin
        e = expected_results.pop_front();
        if (position !== e.position || steps_taken !== e.steps ||
            distinct_visited !== e.visited || max_distance !== e.far ||
            alive !== e.alive || rejected !== e.rejected) begin
          if (mismatches < 10)
            $display({"mismatch: exp pos %0d steps %0d vis %0d max %0d alive %0d rej %0d,",
                      " got %0d %0d %0d %0d %0d %0d"},
                     e.position, e.steps, e.visited, e.far, e.alive, e.rejected,
                     position, steps_taken, distinct_visited, max_distance, alive, rejected);
          mismatches++;
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [9:0] tgts [4];
    rst = 1; start = 0; mode = grwt_pkg::MODE_LOAD_ADJ; node = 0; slot = 0; neighbor = 0;
    degree = 0; target_distance = 0; random_word = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = REG_TARGET; pwdata = 0;
    mismatches = 0; cycles = 0;
    walk_pos = 0; walk_target = 0; walk_far = 0; walk_steps = 0; walk_count = 0;
    foreach (walk_seen[i]) begin
      walk_seen[i] = 0; walk_deg[i] = 0; walk_dist[i] = 0; node_known[i] = 0;
    end
    foreach (walk_adj[i]) begin
      walk_adj[i] = 0; adj_known[i] = 0;
    end

    // Directed: reset state, extremes, rejection cases, absorbing target
    add_row(cmd(grwt_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    add_row(cmd(grwt_pkg::MODE_LOAD_NODE, 0, 0, 0, 2, 5, 0));
    add_row(cmd(grwt_pkg::MODE_LOAD_NODE, 1, 0, 0, 1, 1023, 0));
    add_row(cmd(grwt_pkg::MODE_LOAD_NODE, 1023, 0, 0, 16, 0, 0));
    add_row(cmd(grwt_pkg::MODE_LOAD_NODE, 2, 0, 0, 31, 7, 0));
    add_row(cmd(grwt_pkg::MODE_LOAD_NODE, 3, 0, 0, 0, 3, 0));
    add_row(cmd(grwt_pkg::MODE_LOAD_ADJ, 0, 0, 1, 0, 0, 0));
    add_row(cmd(grwt_pkg::MODE_LOAD_ADJ, 0, 1, 1023, 0, 0, 0));
    add_row(cmd(grwt_pkg::MODE_LOAD_ADJ, 1, 0, 2, 0, 0, 0));
    add_row(cmd(grwt_pkg::MODE_LOAD_ADJ, 1023, 15, 0, 0, 0, 0));
    add_row(cmd(grwt_pkg::MODE_LOAD_ADJ, 1023, 0, 3, 0, 0, 0));
    add_row(cmd(grwt_pkg::MODE_START, 1, 0, 0, 0, 0, 0, 1, 1, 0, 1, 1023, 1, 0));
    add_row(cmd(grwt_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 1, 2, 1, 2, 1023, 1, 0));
    // degree above the limit
    add_row(cmd(grwt_pkg::MODE_STEP, 0, 0, 0, 0, 0, 32'h12345678, 1, 2, 1, 2, 1023, 1, 1));
    add_row(cmd(grwt_pkg::MODE_START, 1023, 0, 0, 0, 0, 0, 1, 1023, 0, 1, 0, 1, 0));
    // slot at degree
    add_row(cmd(grwt_pkg::MODE_STEP, 0, 0, 0, 0, 0, 32'hFFFFFFFF, 1, 1023, 0, 1, 0, 1, 1));
    add_row(cmd(grwt_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 1, 3, 1, 2, 3, 1, 0));
    // degree zero
    add_row(cmd(grwt_pkg::MODE_STEP, 0, 0, 0, 0, 0, 0, 1, 3, 1, 2, 3, 1, 1));
    add_row(cmd(grwt_pkg::MODE_START, 1023, 0, 0, 0, 0, 0, 1, 1023, 0, 1, 0, 1, 0));
    // last slot, lands on the target
    add_row(cmd(grwt_pkg::MODE_STEP, 0, 0, 0, 0, 0, 32'hEFFFFFF1, 1, 0, 1, 2, 5, 0, 0));
    // step at target
    add_row(cmd(grwt_pkg::MODE_STEP, 0, 0, 0, 0, 0, 32'h5A5A5A5A, 1, 0, 1, 2, 5, 0, 0));
    add_row(cmd(grwt_pkg::MODE_START, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 5, 0, 0));

    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    while (busy) @(posedge clk);

    foreach (tbl[i]) send(tbl[i]);

    // Random walks under several targets, extremes first
    tgts[0] = 1023;
    tgts[1] = 0;
    tgts[2] = 10'(pick_known());
    tgts[3] = 10'($urandom_range(1023));
    for (int p = 0; p < 4; p++) begin
      write_target(tgts[p]);
      for (int i = 0; i < RAND_ITEMS / 4; i++) send(random_cmd());
    end

    start <= 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
